/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/gnd_pkg.sv */
`default_nettype none

package gnd_pkg;

  localparam int MAX_INDEX_DEPTH = 4;
  localparam int MAX_SLICE       = 64;

  localparam int COORD_W = 12;
  localparam int DEPTH_W = 3;
  localparam int SLICE_W = 7;
  localparam int POS_W   = 48;
  localparam int SRC_W   = 54;
  localparam int DST_W   = 38;
  localparam int TUPLE_W = 32;
  localparam int K_W     = 6;
  localparam int J_W     = 2;
  localparam int CFG_IDX_W = 3;

  // at most four coordinates travel with a request
  localparam int DEPTH_LIMIT = (MAX_INDEX_DEPTH < 4) ? MAX_INDEX_DEPTH : 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDEX_DEPTH = 3'd0,
    REG_DIM_SIZE_1  = 3'd1,
    REG_DIM_SIZE_2  = 3'd2,
    REG_DIM_SIZE_3  = 3'd3,
    REG_SLICE       = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_SCALE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic fold;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic depth_one;
    logic fold_done;
    logic k_last;
    logic out_free;
  } sts_t;

  function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DEPTH_W'(1);
    end else if (32'(d) > DEPTH_LIMIT) begin
      r = DEPTH_W'(DEPTH_LIMIT);
    end
    return r;
  endfunction

  function automatic logic [SLICE_W-1:0] eff_slice(input logic [SLICE_W-1:0] s);
    logic [SLICE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SLICE_W'(1);
    end else if (32'(s) > MAX_SLICE) begin
      r = SLICE_W'(MAX_SLICE);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/gnd_ctrl.sv */
`default_nettype none

module gnd_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire gnd_pkg::sts_t sts_i,
  output gnd_pkg::cmd_t     cmd_o
);
  import gnd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = sts_i.depth_one ? S_SCALE : S_FOLD;
        end
      end
      S_FOLD: begin
        if (sts_i.fold_done) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.k_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cmd_o.load    = (state_q == S_IDLE) && s_axis_tvalid;
    cmd_o.fold    = (state_q == S_FOLD);
    cmd_o.scale   = (state_q == S_SCALE);
    cmd_o.emit    = (state_q == S_EMIT) && sts_i.out_free;
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_last_emit_idle, cmd_o.emit && sts_i.k_last, state_q == S_IDLE)
  `ASSERT_NEXT(a_scale_then_emit, state_q == S_SCALE, state_q == S_EMIT)
  `ASSERT_NEXT(a_shallow_skips_fold, cmd_o.load && sts_i.depth_one, state_q == S_SCALE)

endmodule

`default_nettype wire

/* sv/gnd_dpath.sv */
`default_nettype none

module gnd_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire gnd_pkg::cmd_t                   cmd_i,
  output gnd_pkg::sts_t                        sts_o,
  input  wire logic [gnd_pkg::DEPTH_W-1:0]     depth_i,
  input  wire logic [gnd_pkg::COORD_W-1:0]     dim_1_i,
  input  wire logic [gnd_pkg::COORD_W-1:0]     dim_2_i,
  input  wire logic [gnd_pkg::COORD_W-1:0]     dim_3_i,
  input  wire logic [gnd_pkg::SLICE_W-1:0]     slice_i,
  input  wire logic [47:0]                     s_axis_tdata,
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [95:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import gnd_pkg::*;

  logic [COORD_W-1:0] coord_q [4];
  logic               final_q;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [J_W-1:0]     j_q;
  logic [K_W-1:0]     k_q;
  logic [SRC_W-1:0]   src_q;
  logic [DST_W-1:0]   dst_q;
  logic [TUPLE_W-1:0] tuple_q;
  logic               out_valid_q;
  logic [SRC_W-1:0]   out_src_q;
  logic [DST_W-1:0]   out_dst_q;
  logic               out_last_q;

  logic [COORD_W-1:0] dim_sel;
  logic [59:0]        fold_prod;
  logic [SRC_W:0]     src_prod;
  logic [DST_W:0]     dst_prod;

  always_comb begin
    case (j_q)
      2'd1:    dim_sel = dim_1_i;
      2'd2:    dim_sel = dim_2_i;
      2'd3:    dim_sel = dim_3_i;
      default: dim_sel = '0;
    endcase
  end

  assign fold_prod = {12'b0, pos_q} * {48'b0, dim_sel};
  assign pos_d     = fold_prod[POS_W-1:0] + {36'b0, coord_q[j_q]};
  assign src_prod  = {7'b0, pos_q} * {48'b0, slice_i};
  assign dst_prod  = {7'b0, tuple_q} * {32'b0, slice_i};

  assign sts_o.depth_one = (depth_i == DEPTH_W'(1));
  assign sts_o.fold_done = ({1'b0, j_q} == depth_i - DEPTH_W'(1));
  assign sts_o.k_last    = ({1'b0, k_q} == slice_i - SLICE_W'(1));
  assign sts_o.out_free  = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 4; i++) begin
        coord_q[i] <= s_axis_tdata[i*COORD_W +: COORD_W];
      end
      final_q <= s_axis_tlast;
      pos_q   <= {36'b0, s_axis_tdata[COORD_W-1:0]};
    end else if (cmd_i.fold) begin
      pos_q <= pos_d;
    end
    if (cmd_i.scale) begin
      src_q <= src_prod[SRC_W-1:0];
      dst_q <= dst_prod[DST_W-1:0];
    end else if (cmd_i.emit) begin
      src_q <= src_q + SRC_W'(1);
      dst_q <= dst_q + DST_W'(1);
    end
    if (cmd_i.emit) begin
      out_src_q  <= src_q;
      out_dst_q  <= dst_q;
      out_last_q <= sts_o.k_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= J_W'(1);
      k_q         <= '0;
      tuple_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        j_q <= J_W'(1);
      end else if (cmd_i.fold && !sts_o.fold_done) begin
        j_q <= j_q + J_W'(1);
      end
      if (cmd_i.scale) begin
        k_q     <= '0;
        tuple_q <= final_q ? '0 : tuple_q + TUPLE_W'(1);
      end else if (cmd_i.emit) begin
        k_q <= sts_o.k_last ? '0 : k_q + K_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_dst_q, out_src_q};
  assign m_axis_tlast  = out_last_q;

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_k_range, 1'b1, {1'b0, k_q} < slice_i)
  `ASSERT_IMPL(a_j_range, cmd_i.fold, {1'b0, j_q} < depth_i)
  `ASSERT_NEXT(a_end_marked, cmd_i.emit && sts_o.k_last, m_axis_tlast && k_q == '0)

endmodule

`default_nettype wire

/* sv/gather_nd_address_generator_unit.sv */
// A request is taken in the idle state and passes through the fold (skipped for
// index depth 1), scale and emit states; the next is taken only after the last
//   slice element is emitted. The fold multiplier takes one coordinate per cycle;
//   the output register emits one slice element per cycle while not stalled.
// Reset (rst_ni low, async): registers return to 1, tuple counter to zero, no
//   result pending; the unit leaves reset idle and ready to take a request.
`default_nettype none

module gather_nd_address_generator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gnd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [gnd_pkg::COORD_W-1:0]       cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // coord_0 [11:0], coord_1 [23:12], coord_2 [35:24], coord_3 [47:36]
  input  wire logic [47:0]                       s_axis_tdata,
  input  wire logic                              s_axis_tlast,  // final_tuple
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // src_offset [53:0], dst_offset [91:54], zero [95:92]
  output logic [95:0]                            m_axis_tdata,
  output logic                                   m_axis_tlast   // slice_end
);
  import gnd_pkg::*;

  logic [DEPTH_W-1:0] depth_q;
  logic [COORD_W-1:0] dim_1_q, dim_2_q, dim_3_q;
  logic [SLICE_W-1:0] slice_q;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_W'(1);
      dim_1_q <= COORD_W'(1);
      dim_2_q <= COORD_W'(1);
      dim_3_q <= COORD_W'(1);
      slice_q <= SLICE_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_INDEX_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        REG_DIM_SIZE_1:  dim_1_q <= cfg_data_i;
        REG_DIM_SIZE_2:  dim_2_q <= cfg_data_i;
        REG_DIM_SIZE_3:  dim_3_q <= cfg_data_i;
        REG_SLICE:       slice_q <= cfg_data_i[SLICE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gnd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  gnd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .depth_i       (eff_depth(depth_q)),
    .dim_1_i       (dim_1_q),
    .dim_2_i       (dim_2_q),
    .dim_3_i       (dim_3_q),
    .slice_i       (eff_slice(slice_q)),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
